@@ src/bitmap_block_allocator_top_macros.svh @@
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bba same-cycle check failed");
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bba next-cycle check failed");
`else
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/bba_pkg.sv @@
// shared widths, codes and defaults for the bitmap block allocator
package bba_pkg;
	localparam int MAX_BLOCKS_DEF = 4096;
	localparam int WORD_BITS_DEF = 64;

	localparam int ACT_W = 2;
	localparam int BLK_W = 13;
	localparam int ST_W = 2;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [ST_W-1:0] status_t;

	localparam action_t ACT_ALLOC = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_MARK = 2'd2;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_NONE = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	localparam blk_t BLK_RESET = 13'd4096;
endpackage

@@ src/bba_req_if.sv @@
// request channel: action, block number and mark value
interface bba_req_if import bba_pkg::*; ();
	logic valid;
	logic ready;
	action_t action;
	blk_t block_number;
	logic mark_used;

	modport source (output valid, output action, output block_number, output mark_used,
		input ready);
	modport sink (input valid, input action, input block_number, input mark_used,
		output ready);
endinterface

@@ src/bba_rsp_if.sv @@
// response channel: status and granted block
interface bba_rsp_if import bba_pkg::*; ();
	logic valid;
	logic ready;
	status_t status;
	blk_t granted_block;

	modport source (output valid, output status, output granted_block, input ready);
	modport sink (input valid, input status, input granted_block, output ready);
endinterface

@@ src/bba_word_scan.sv @@
// lowest free bit of one map word, limited to blocks below the count
module bba_word_scan import bba_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CW = 13,
	localparam int LG = $clog2(WORD_BITS)
) (
	input logic [WORD_BITS-1:0] word,
	input logic [CW-1:0] base,
	input logic [CW-1:0] count,
	output logic found,
	output logic [LG-1:0] pos
);
	logic [CW-1:0] rem;
	logic [WORD_BITS-1:0] avail;

	// blocks left in the map from this word on
	assign rem = count - base;

	always_comb begin
		if (rem >= CW'(WORD_BITS)) begin
			avail = ~word;
		end else begin
			avail = ~word & ((WORD_BITS'(1) << rem) - WORD_BITS'(1));
		end
		found = |avail;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pos = LG'(i);
			end
		end
	end
endmodule

@@ src/bitmap_block_allocator_top.sv @@
// bitmap first-fit block allocator, top level
`include "bitmap_block_allocator_top_macros.svh"
// One used/free bit per block, blocks numbered from 1, kept in a single-port-write,
// registered-read memory of WORD_BITS-wide words (WORD_BITS a power of two). After
// reset a clearing pass writes zeros to all NUM_WORDS words, one a cycle, and no
// word is taken until it is done; register writes are taken throughout. Allocate
// streams the map through the word scanner one word a cycle until a hit or the end
// of the count, and answers none without a scan when the free hint is clear.
// Release and mark are a read-modify-write of one word (UPD_RD, then UPD_WR); a bad
// block number or unused action goes straight to the response. One word is in work
// at a time. The result sits in an output register, so the next word is taken
// while it waits.
module bitmap_block_allocator_top import bba_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	bba_req_if.sink req,
	bba_rsp_if.source rsp,
	input logic cfg_we,
	input blk_t cfg_wdata
);
	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int LG = $clog2(WORD_BITS);
	localparam int WA = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(NUM_WORDS * WORD_BITS + 1);

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		UPD_RD,
		UPD_WR,
		SCAN,
		RESP
	} state_t;

	state_t state_q;
	logic hint_q;
	blk_t blocks_q;
	logic [WA-1:0] clr_addr_q;
	logic [WA-1:0] upd_word_q;
	logic [LG-1:0] upd_bit_q;
	logic upd_set_q;
	logic [WA-1:0] scan_word_q;
	logic [CW-1:0] scan_base_q;
	logic chk_vld_s1;
	logic [WA-1:0] chk_word_s1;
	logic [CW-1:0] chk_base_s1;
	status_t res_status_q;
	blk_t res_grant_q;
	logic out_vld_q;
	status_t out_status_q;
	blk_t out_grant_q;

	logic [WORD_BITS-1:0] map_mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic mem_we;
	logic [WA-1:0] mem_waddr;
	logic [WA-1:0] mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic [CW-1:0] count;
	logic blk_bad;
	logic [IW-1:0] req_idx;
	logic scan_issue;
	logic hit_found;
	logic [LG-1:0] hit_pos;
	logic scan_hit;
	logic scan_none;
	logic out_load;

	// effective block count, saturated to the map size
	assign count = (32'(blocks_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(blocks_q);

	assign blk_bad = (req.block_number == '0) || (32'(req.block_number) > 32'(count));
	assign req_idx = IW'(req.block_number - BLK_W'(1));

	assign scan_issue = (scan_base_q < count);
	assign scan_hit = chk_vld_s1 && hit_found;
	assign scan_none = !chk_vld_s1 && !scan_issue;

	assign out_load = (state_q == RESP) && (!out_vld_q || rsp.ready);

	bba_word_scan #(
		.WORD_BITS(WORD_BITS),
		.CW(CW)
	) u_scan (
		.word(rdata_q),
		.base(chk_base_s1),
		.count(count),
		.found(hit_found),
		.pos(hit_pos)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		mem_raddr = scan_word_q;
		unique case (state_q)
			CLEAR: begin
				mem_we = 1'b1;
			end
			UPD_RD: begin
				mem_raddr = upd_word_q;
			end
			UPD_WR: begin
				mem_we = 1'b1;
				mem_waddr = upd_word_q;
				mem_wdata = rdata_q;
				mem_wdata[upd_bit_q] = upd_set_q;
			end
			SCAN: begin
				if (scan_hit) begin
					mem_we = 1'b1;
					mem_waddr = chk_word_s1;
					mem_wdata = rdata_q | (WORD_BITS'(1) << hit_pos);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= map_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			hint_q <= 1'b1;
			blocks_q <= BLK_RESET;
			clr_addr_q <= '0;
			upd_word_q <= '0;
			upd_bit_q <= '0;
			upd_set_q <= 1'b0;
			scan_word_q <= '0;
			scan_base_q <= '0;
			chk_vld_s1 <= 1'b0;
			chk_word_s1 <= '0;
			chk_base_s1 <= '0;
			res_status_q <= ST_OK;
			res_grant_q <= '0;
			out_vld_q <= 1'b0;
			out_status_q <= ST_OK;
			out_grant_q <= '0;
		end else begin
			if (cfg_we) begin
				blocks_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					clr_addr_q <= clr_addr_q + WA'(1);
					if (clr_addr_q == WA'(NUM_WORDS - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (req.valid) begin
						res_grant_q <= '0;
						upd_word_q <= WA'(req_idx >> LG);
						upd_bit_q <= req_idx[LG-1:0];
						upd_set_q <= (req.action == ACT_MARK) && req.mark_used;
						scan_word_q <= '0;
						scan_base_q <= '0;
						chk_vld_s1 <= 1'b0;
						case (req.action)
							ACT_ALLOC: begin
								if (hint_q) begin
									res_status_q <= ST_OK;
									state_q <= SCAN;
								end else begin
									res_status_q <= ST_NONE;
									state_q <= RESP;
								end
							end
							ACT_RELEASE, ACT_MARK: begin
								if (blk_bad) begin
									res_status_q <= ST_RANGE;
									state_q <= RESP;
								end else begin
									res_status_q <= ST_OK;
									state_q <= UPD_RD;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q <= RESP;
							end
						endcase
					end
				end
				UPD_RD: begin
					state_q <= UPD_WR;
				end
				UPD_WR: begin
					// release and mark-free both reopen the search
					if (!upd_set_q) begin
						hint_q <= 1'b1;
					end
					state_q <= RESP;
				end
				SCAN: begin
					chk_vld_s1 <= scan_issue;
					chk_word_s1 <= scan_word_q;
					chk_base_s1 <= scan_base_q;
					if (scan_issue) begin
						scan_word_q <= scan_word_q + WA'(1);
						scan_base_q <= scan_base_q + CW'(WORD_BITS);
					end
					if (scan_hit) begin
						res_grant_q <= BLK_W'(chk_base_s1 + CW'(hit_pos) + CW'(1));
						state_q <= RESP;
					end else if (scan_none) begin
						hint_q <= 1'b0;
						res_status_q <= ST_NONE;
						state_q <= RESP;
					end
				end
				RESP: begin
					if (out_load) begin
						out_status_q <= res_status_q;
						out_grant_q <= res_grant_q;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.granted_block = out_grant_q;

	// a granted block always comes with ok status
	`BBA_ASSERT_IMP(a_grant_ok, clk, arst_n, rsp.valid && (rsp.granted_block != '0),
		rsp.status == ST_OK)
	// a search that runs dry leaves the hint clear
	`BBA_ASSERT_NXT(a_dry_hint, clk, arst_n, (state_q == SCAN) && scan_none, !hint_q)
	// the block is busy right after taking a word
	`BBA_ASSERT_NXT(a_busy, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule
